// ===== design/txw_pkg.sv =====
// Shared types and constants for the text console writer.
package txw_pkg;

    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int COORD_W  = 8;
    localparam int COLOR_W  = 8;
    localparam int IDX_W    = 11;
    localparam int OCOL_W   = 7;
    localparam int OROW_W   = 5;
    localparam int CELL_W   = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_SET   = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    localparam logic [CHAR_W-1:0]  CHAR_BS       = 8'h08;
    localparam logic [CHAR_W-1:0]  CHAR_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0]  CHAR_NEWLINE  = 8'h0A;
    localparam logic [CHAR_W-1:0]  CHAR_BLANK    = 8'h20;
    localparam logic [COLOR_W-1:0] COLOR_DEFAULT = 8'h07;
    localparam logic [CELL_W-1:0]  SCROLL_FILL   = 16'h0720;

endpackage

// ===== design/txw_if.sv =====
// Valid/ready channel interfaces for the console command and result streams.
interface txw_in_if;
    import txw_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [CHAR_W-1:0]   char_code;
    logic [COORD_W-1:0]  column;
    logic [COORD_W-1:0]  row;

    modport source (output valid, action, char_code, column, row, input ready);
    modport sink   (input valid, action, char_code, column, row, output ready);
endinterface

interface txw_out_if;
    import txw_pkg::*;

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  cursor_index;
    logic [OCOL_W-1:0] cursor_column;
    logic [OROW_W-1:0] cursor_row;
    logic [CELL_W-1:0] cell_value;

    modport source (output valid, cursor_index, cursor_column, cursor_row, cell_value,
                    input ready);
    modport sink   (input valid, cursor_index, cursor_column, cursor_row, cell_value,
                    output ready);
endinterface

// ===== design/text_console_writer_unit.sv =====
// Text console writer: cell store, cursor and command sequencer.
//
// Usage: commands arrive on i_in (action, char_code, column, row); every
// command returns exactly one result on o_out (cursor position after the
// command, plus the cell word for a read). i_cfg_we/i_cfg_wdata set the
// attribute byte used for written and cleared cells; write it while idle.
// All cell state lives in one simple dual-port synchronous RAM of
// SCREEN_WIDTH*SCREEN_HEIGHT 16-bit words, one write and one read per cycle.
// Steps from accept to result valid: set cursor and newline without scroll
// go straight to the result; read waits for the RAM word; printable and
// backspace write one cell; tab blanks up to the next tab stop, every fourth
// column; clear fills all cells; a scroll moves rows up and blanks the last.
// One command is in flight at a time; the next is taken once the result
// register is free or being emptied in the same cycle.
// Reset: the cursor goes home, the attribute to 7, and a clearing pass over
// all W*H cells fills the store with 0x0720; no command is
// taken meanwhile, configuration writes are.
// A stalled receiver holds the result in the output register and blocks
// new commands until it is taken.
module text_console_writer_unit #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    txw_in_if.sink                      i_in,
    txw_out_if.source                   o_out,
    input  logic                        i_cfg_we,
    input  logic [txw_pkg::COLOR_W-1:0] i_cfg_wdata
);
    import txw_pkg::*;

    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(SCREEN_WIDTH);
    localparam int LW    = $clog2(SCREEN_HEIGHT);

    localparam logic [AW-1:0] LAST_ADDR   = AW'(CELLS - 1);
    localparam logic [AW-1:0] BOTTOM_ADDR = AW'(CELLS - SCREEN_WIDTH);
    localparam logic [AW-1:0] ROW_STRIDE  = AW'(SCREEN_WIDTH);
    localparam logic [CW-1:0] LAST_COL    = CW'(SCREEN_WIDTH - 1);
    localparam logic [LW-1:0] LAST_LINE   = LW'(SCREEN_HEIGHT - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUT,
        S_READ,
        S_SCROLL,
        S_FILL,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PM_CHAR,
        PM_TAB,
        PM_BS
    } t_put_mode;

    t_state            r_state;
    t_put_mode         r_mode;
    logic [AW-1:0]     r_addr;
    logic [CELL_W-1:0] r_fill_data;
    logic              r_item;
    logic [CW-1:0]     r_col;
    logic [LW-1:0]     r_line;
    logic [COLOR_W-1:0] r_color;
    logic [CHAR_W-1:0] r_char;
    logic [CELL_W-1:0] r_cell;
    logic [CELL_W-1:0] r_rdata;

    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_idx;
    logic [OCOL_W-1:0] r_out_col;
    logic [OROW_W-1:0] r_out_row;
    logic [CELL_W-1:0] r_out_cell;

    logic [CELL_W-1:0] mem [CELLS];

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    logic              in_take;
    logic              in_range;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     cur_addr;
    t_action           act;
    logic              last_col;
    logic              last_line;

    assign act       = t_action'(i_in.action);
    assign in_take   = i_in.valid && i_in.ready;
    assign in_range  = (int'(i_in.column) < SCREEN_WIDTH) && (int'(i_in.row) < SCREEN_HEIGHT);
    assign rd_addr   = AW'(int'(i_in.row) * SCREEN_WIDTH + int'(i_in.column));
    assign cur_addr  = AW'(int'(r_line) * SCREEN_WIDTH + int'(r_col));
    assign last_col  = (r_col == LAST_COL);
    assign last_line = (r_line == LAST_LINE);

    assign i_in.ready          = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign o_out.valid         = r_out_valid;
    assign o_out.cursor_index  = r_out_idx;
    assign o_out.cursor_column = r_out_col;
    assign o_out.cursor_row    = r_out_row;
    assign o_out.cell_value    = r_out_cell;

    // RAM port steering
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_fill_data;
        mem_re    = 1'b0;
        mem_raddr = rd_addr;
        case (r_state)
            S_FILL: begin
                mem_we = 1'b1;
            end
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = cur_addr;
                mem_wdata = {r_color, r_char};
            end
            S_SCROLL: begin
                // read one row below, write back the word read last cycle
                mem_we    = (r_addr != '0);
                mem_waddr = r_addr - AW'(1);
                mem_wdata = r_rdata;
                mem_re    = (r_addr < BOTTOM_ADDR);
                mem_raddr = r_addr + ROW_STRIDE;
            end
            S_IDLE: begin
                mem_re = in_take && (act == ACT_READ) && in_range;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_mode      <= PM_CHAR;
            r_addr      <= '0;
            r_fill_data <= SCROLL_FILL;
            r_item      <= 1'b0;
            r_col       <= '0;
            r_line      <= '0;
            r_color     <= COLOR_DEFAULT;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_color <= i_cfg_wdata;
            end
            if (o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_cell <= '0;
                        case (act)
                            ACT_PUT: begin
                                case (i_in.char_code)
                                    CHAR_NEWLINE: begin
                                        r_col <= '0;
                                        if (last_line) begin
                                            r_addr  <= '0;
                                            r_state <= S_SCROLL;
                                        end else begin
                                            r_line  <= r_line + LW'(1);
                                            r_state <= S_DONE;
                                        end
                                    end
                                    CHAR_BS: begin
                                        r_char  <= CHAR_BLANK;
                                        r_mode  <= PM_BS;
                                        r_state <= S_PUT;
                                        if (r_col == '0) begin
                                            if (r_line != '0) begin
                                                r_col  <= LAST_COL;
                                                r_line <= r_line - LW'(1);
                                            end
                                        end else begin
                                            r_col <= r_col - CW'(1);
                                        end
                                    end
                                    CHAR_TAB: begin
                                        r_char  <= CHAR_BLANK;
                                        r_mode  <= PM_TAB;
                                        r_state <= S_PUT;
                                    end
                                    default: begin
                                        r_char  <= i_in.char_code;
                                        r_mode  <= PM_CHAR;
                                        r_state <= S_PUT;
                                    end
                                endcase
                            end
                            ACT_CLEAR: begin
                                r_col       <= '0;
                                r_line      <= '0;
                                r_addr      <= '0;
                                r_fill_data <= {r_color, CHAR_BLANK};
                                r_item      <= 1'b1;
                                r_state     <= S_FILL;
                            end
                            ACT_SET: begin
                                if (int'(i_in.column) < SCREEN_WIDTH) begin
                                    r_col <= CW'(i_in.column);
                                end
                                if (int'(i_in.row) < SCREEN_HEIGHT) begin
                                    r_line <= LW'(i_in.row);
                                end
                                r_state <= S_DONE;
                            end
                            ACT_READ: begin
                                r_state <= in_range ? S_READ : S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_PUT: begin
                    // cell is written this cycle; now advance the cursor, except after a backspace
                    if (r_mode == PM_BS) begin
                        r_state <= S_DONE;
                    end else if (r_mode == PM_TAB && r_col[1:0] != 2'b11 && !last_col) begin
                        r_col <= r_col + CW'(1);
                    end else if (last_col) begin
                        r_col <= '0;
                        if (last_line) begin
                            r_addr  <= '0;
                            r_state <= S_SCROLL;
                        end else begin
                            r_line  <= r_line + LW'(1);
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_col   <= r_col + CW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_READ: begin
                    r_cell  <= r_rdata;
                    r_state <= S_DONE;
                end
                S_SCROLL: begin
                    if (r_addr == BOTTOM_ADDR) begin
                        r_fill_data <= SCROLL_FILL;
                        r_item      <= 1'b1;
                        r_state     <= S_FILL;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_FILL: begin
                    if (r_addr == LAST_ADDR) begin
                        r_state <= r_item ? S_DONE : S_IDLE;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_out_idx   <= IDX_W'(int'(r_line) * SCREEN_WIDTH + int'(r_col));
                    r_out_col   <= OCOL_W'(r_col);
                    r_out_row   <= OROW_W'(r_line);
                    r_out_cell  <= r_cell;
                    r_item      <= 1'b0;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/txw_checker.sv =====
// Port-level assertions for the text console writer, bound to the top level.
module txw_checker #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [txw_pkg::IDX_W-1:0]  i_out_index,
    input logic [txw_pkg::OCOL_W-1:0] i_out_column,
    input logic [txw_pkg::OROW_W-1:0] i_out_row,
    input logic [txw_pkg::CELL_W-1:0] i_out_cell
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_index)
            && $stable(i_out_column) && $stable(i_out_row) && $stable(i_out_cell))
        else $error("result changed while stalled");

    // one command in flight: no back-to-back accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command accepted while another is in flight");

    // no new command while a result is stuck at the output
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("command accepted while result stalled");

    // reported cursor lies on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (int'(i_out_column) < SCREEN_WIDTH)
            && (int'(i_out_row) < SCREEN_HEIGHT))
        else $error("cursor off screen");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind text_console_writer_unit txw_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_txw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_index  (o_out.cursor_index),
    .i_out_column (o_out.cursor_column),
    .i_out_row    (o_out.cursor_row),
    .i_out_cell   (o_out.cell_value)
);
